// ===== sv/tror_pkg.sv =====
package tror_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned ProdW  = 34;
  localparam int unsigned SumW   = 64;
  localparam int unsigned NLanes = 12;

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_SQR  = 3'd1;
  localparam logic [2:0] F_SQRT = 3'd2;
  localparam logic [2:0] F_DIV  = 3'd3;
  localparam logic [2:0] F_DONE = 3'd4;

  typedef struct packed {
    logic signed [DataW-1:0] a_even_re;
    logic signed [DataW-1:0] a_even_im;
    logic signed [DataW-1:0] a_odd_re;
    logic signed [DataW-1:0] a_odd_im;
    logic signed [DataW-1:0] b_even_re;
    logic signed [DataW-1:0] b_even_im;
    logic signed [DataW-1:0] b_odd_re;
    logic signed [DataW-1:0] b_odd_im;
    logic                    last_item;
  } in_item_t;

  typedef struct packed {
    logic [DataW-1:0] overlap_ratio;
    logic             ratio_saturated;
    logic             norm_zero;
  } out_item_t;

endpackage

// ===== sv/tror_in_if.sv =====
interface tror_in_if;
  logic               valid;
  logic               ready;
  tror_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/tror_out_if.sv =====
interface tror_out_if;
  logic                valid;
  logic                ready;
  tror_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/time_reversal_overlap_ratio.sv =====
// channel  | dir | handshake            | payload
// in_ch    | in  | valid/ready transfer | A, B component pair, last_item
// out_ch   | out | valid/ready transfer | overlap_ratio, ratio_saturated, norm_zero
//
// Non-last items: one per cycle while input is open, 12 lane multipliers feed the running sums.
// Last item: the sums are folded, then squared (one 32x32 multiplier), square-rooted
//   (one bit a cycle) and divided (one bit a cycle), unless a zero norm or a saturated
//   ratio ends it early; input is held off until the result is loaded in the output register.
// Reset: rst_n synchronous, clears sums and control.
// A stalled output holds its result; input stays open until the next last item.
module time_reversal_overlap_ratio (
  input  logic       clk,
  input  logic       rst_n,
  tror_in_if.sink    in_ch,
  tror_out_if.source out_ch
);

  logic signed [tror_pkg::DataW-1:0] op_a [tror_pkg::NLanes];
  logic signed [tror_pkg::DataW-1:0] op_b [tror_pkg::NLanes];
  logic signed [tror_pkg::ProdW-1:0] prod [tror_pkg::NLanes];
  logic v1_r, last1_r, busy_r, out_valid_r;
  logic in_fire, can_load, done;
  logic [tror_pkg::SumW-1:0] re_tot, im_tot, nr_tot;
  tror_pkg::out_item_t res, out_data_r;
  tror_pkg::in_item_t  d;

  assign d = in_ch.data;

  always_comb begin
    op_a[0]  = d.a_even_im; op_b[0]  = d.b_odd_im;
    op_a[1]  = d.a_even_re; op_b[1]  = d.b_odd_re;
    op_a[2]  = d.a_odd_re;  op_b[2]  = d.b_even_re;
    op_a[3]  = d.a_odd_im;  op_b[3]  = d.b_even_im;
    op_a[4]  = d.a_even_re; op_b[4]  = d.b_odd_im;
    op_a[5]  = d.a_even_im; op_b[5]  = d.b_odd_re;
    op_a[6]  = d.a_odd_re;  op_b[6]  = d.b_even_im;
    op_a[7]  = d.a_odd_im;  op_b[7]  = d.b_even_re;
    op_a[8]  = d.a_even_re; op_b[8]  = d.a_even_re;
    op_a[9]  = d.a_even_im; op_b[9]  = d.a_even_im;
    op_a[10] = d.a_odd_re;  op_b[10] = d.a_odd_re;
    op_a[11] = d.a_odd_im;  op_b[11] = d.a_odd_im;
  end

  for (genvar g = 0; g < tror_pkg::NLanes; g++) begin : g_lane
    tror_lane u_lane (.clk(clk), .a_i(op_a[g]), .b_i(op_b[g]), .p_r(prod[g]));
  end

  tror_merge u_merge (
    .clk(clk), .rst_n(rst_n), .p_i(prod), .add_en_i(v1_r), .clear_i(last1_r),
    .re_tot_o(re_tot), .im_tot_o(im_tot), .nr_tot_o(nr_tot)
  );

  assign can_load = !out_valid_r || out_ch.ready;

  tror_finish u_finish (
    .clk(clk), .rst_n(rst_n), .start_i(v1_r && last1_r),
    .re_i(re_tot), .im_i(im_tot), .n_i(nr_tot),
    .take_i(can_load), .done_o(done), .res_o(res)
  );

  assign in_ch.ready = !busy_r;
  assign in_fire     = in_ch.valid && !busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      last1_r     <= 1'b0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r    <= in_fire;
      last1_r <= in_fire && d.last_item;
      if (in_fire && d.last_item) begin
        busy_r <= 1'b1;
      end else if (done && can_load) begin
        busy_r <= 1'b0;
      end
      if (done && can_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done && can_load) out_data_r <= res;
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

endmodule

// ===== sv/tror_lane.sv =====
module tror_lane (
  input  logic                                 clk,
  input  logic signed [tror_pkg::DataW-1:0]    a_i,
  input  logic signed [tror_pkg::DataW-1:0]    b_i,
  output logic signed [tror_pkg::ProdW-1:0]    p_r
);

  logic signed [2*tror_pkg::DataW-1:0] prod;
  logic signed [2*tror_pkg::DataW-1:0] rnd;
  logic signed [tror_pkg::ProdW-1:0]   p_nxt;

  assign prod  = a_i * b_i;
  assign rnd   = prod + (64'sd1 <<< 29);
  assign p_nxt = rnd[63:30];

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
  end

endmodule

// ===== sv/tror_merge.sv =====
module tror_merge (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic signed [tror_pkg::ProdW-1:0]   p_i [tror_pkg::NLanes],
  input  logic                                add_en_i,
  input  logic                                clear_i,
  output logic [tror_pkg::SumW-1:0]           re_tot_o,
  output logic [tror_pkg::SumW-1:0]           im_tot_o,
  output logic [tror_pkg::SumW-1:0]           nr_tot_o
);

  logic [tror_pkg::SumW-1:0] ext [tror_pkg::NLanes];
  logic [tror_pkg::SumW-1:0] re_sum_r, im_sum_r, nr_sum_r;
  logic [tror_pkg::SumW-1:0] re_sum_nxt, im_sum_nxt, nr_sum_nxt;

  always_comb begin
    for (int i = 0; i < tror_pkg::NLanes; i++) begin
      ext[i] = {{(tror_pkg::SumW-tror_pkg::ProdW){p_i[i][tror_pkg::ProdW-1]}}, p_i[i]};
    end
  end

  assign re_tot_o = re_sum_r + ext[0] - ext[1] + ext[2] - ext[3];
  assign im_tot_o = im_sum_r + ext[4] + ext[5] - ext[6] - ext[7];
  assign nr_tot_o = nr_sum_r + ext[8] + ext[9] + ext[10] + ext[11];

  always_comb begin
    re_sum_nxt = re_sum_r;
    im_sum_nxt = im_sum_r;
    nr_sum_nxt = nr_sum_r;
    if (add_en_i) begin
      if (clear_i) begin
        re_sum_nxt = '0;
        im_sum_nxt = '0;
        nr_sum_nxt = '0;
      end else begin
        re_sum_nxt = re_tot_o;
        im_sum_nxt = im_tot_o;
        nr_sum_nxt = nr_tot_o;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      re_sum_r <= '0;
      im_sum_r <= '0;
      nr_sum_r <= '0;
    end else begin
      re_sum_r <= re_sum_nxt;
      im_sum_r <= im_sum_nxt;
      nr_sum_r <= nr_sum_nxt;
    end
  end

endmodule

// ===== sv/tror_finish.sv =====
module tror_finish (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start_i,
  input  logic [tror_pkg::SumW-1:0]     re_i,
  input  logic [tror_pkg::SumW-1:0]     im_i,
  input  logic [tror_pkg::SumW-1:0]     n_i,
  input  logic                          take_i,
  output logic                          done_o,
  output tror_pkg::out_item_t           res_o
);

  logic [2:0]   state_r, state_nxt;
  logic [5:0]   cnt_r, cnt_nxt;
  logic [63:0]  ur_r, ui_r, n_r;
  logic [127:0] acc_r, acc_nxt;
  logic [63:0]  root_r, root_nxt;
  logic [66:0]  rem_r, rem_nxt;
  logic [64:0]  drem_r, drem_nxt;
  logic [31:0]  dsh_r, dsh_nxt;
  logic [31:0]  q_r, q_nxt;
  tror_pkg::out_item_t res_r, res_nxt;

  logic [31:0]  ma, mb;
  logic [63:0]  pp;
  logic [127:0] pp_sh;
  logic [66:0]  rem_t, trial;
  logic [64:0]  dt;
  logic [63:0]  ur_in, ui_in;

  assign ur_in = re_i[63] ? (64'd0 - re_i) : re_i;
  assign ui_in = im_i[63] ? (64'd0 - im_i) : im_i;

  always_comb begin
    unique case (cnt_r)
      6'd0:    begin ma = ur_r[31:0];  mb = ur_r[31:0];  end
      6'd1:    begin ma = ur_r[31:0];  mb = ur_r[63:32]; end
      6'd2:    begin ma = ur_r[63:32]; mb = ur_r[63:32]; end
      6'd3:    begin ma = ui_r[31:0];  mb = ui_r[31:0];  end
      6'd4:    begin ma = ui_r[31:0];  mb = ui_r[63:32]; end
      6'd5:    begin ma = ui_r[63:32]; mb = ui_r[63:32]; end
      default: begin ma = '0;          mb = '0;          end
    endcase
  end

  assign pp = ma * mb;

  always_comb begin
    unique case (cnt_r)
      6'd1, 6'd4: pp_sh = {31'd0, pp, 33'd0};
      6'd2, 6'd5: pp_sh = {pp, 64'd0};
      default:    pp_sh = {64'd0, pp};
    endcase
  end

  assign rem_t = {rem_r[64:0], acc_r[127:126]};
  assign trial = {1'b0, root_r, 2'b01};
  assign dt    = {drem_r[63:0], dsh_r[31]};

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    root_nxt  = root_r;
    rem_nxt   = rem_r;
    drem_nxt  = drem_r;
    dsh_nxt   = dsh_r;
    q_nxt     = q_r;
    res_nxt   = res_r;
    unique case (state_r)
      tror_pkg::F_IDLE: begin
        if (start_i) begin
          cnt_nxt = '0;
          acc_nxt = '0;
          if (n_i == '0) begin
            res_nxt   = '{overlap_ratio: '0, ratio_saturated: 1'b0, norm_zero: 1'b1};
            state_nxt = tror_pkg::F_DONE;
          end else begin
            state_nxt = tror_pkg::F_SQR;
          end
        end
      end
      tror_pkg::F_SQR: begin
        acc_nxt = acc_r + pp_sh;
        if (cnt_r == 6'd5) begin
          cnt_nxt   = 6'd63;
          root_nxt  = '0;
          rem_nxt   = '0;
          state_nxt = tror_pkg::F_SQRT;
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end
      tror_pkg::F_SQRT: begin
        acc_nxt = {acc_r[125:0], 2'b00};
        if (rem_t >= trial) begin
          rem_nxt  = rem_t - trial;
          root_nxt = {root_r[62:0], 1'b1};
        end else begin
          rem_nxt  = rem_t;
          root_nxt = {root_r[62:0], 1'b0};
        end
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == '0) begin
          if ({4'd0, root_nxt[63:4]} >= n_r) begin
            res_nxt   = '{overlap_ratio: '1, ratio_saturated: 1'b1, norm_zero: 1'b0};
            state_nxt = tror_pkg::F_DONE;
          end else begin
            drem_nxt  = {5'd0, root_nxt[63:4]};
            dsh_nxt   = {root_nxt[3:0], 28'd0};
            q_nxt     = '0;
            cnt_nxt   = 6'd31;
            state_nxt = tror_pkg::F_DIV;
          end
        end
      end
      tror_pkg::F_DIV: begin
        dsh_nxt = {dsh_r[30:0], 1'b0};
        if (dt >= {1'b0, n_r}) begin
          drem_nxt = dt - {1'b0, n_r};
          q_nxt    = {q_r[30:0], 1'b1};
        end else begin
          drem_nxt = dt;
          q_nxt    = {q_r[30:0], 1'b0};
        end
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == '0) begin
          res_nxt   = '{overlap_ratio: q_nxt, ratio_saturated: 1'b0, norm_zero: 1'b0};
          state_nxt = tror_pkg::F_DONE;
        end
      end
      tror_pkg::F_DONE: begin
        if (take_i) state_nxt = tror_pkg::F_IDLE;
      end
      default: state_nxt = tror_pkg::F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tror_pkg::F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    acc_r  <= acc_nxt;
    root_r <= root_nxt;
    rem_r  <= rem_nxt;
    drem_r <= drem_nxt;
    dsh_r  <= dsh_nxt;
    q_r    <= q_nxt;
    res_r  <= res_nxt;
    if (state_r == tror_pkg::F_IDLE && start_i) begin
      ur_r <= ur_in;
      ui_r <= ui_in;
      n_r  <= n_i;
    end
  end

  assign done_o = (state_r == tror_pkg::F_DONE);
  assign res_o  = res_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start_i |-> state_r == tror_pkg::F_IDLE) else $error("start while busy");

  a_zero_fast: assert property (@(posedge clk) disable iff (!rst_n)
    start_i && n_i == '0 |=> state_r == tror_pkg::F_DONE && res_r.norm_zero)
    else $error("zero norm not flagged");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    done_o |-> !(res_r.ratio_saturated && res_r.norm_zero)) else $error("flags clash");

endmodule

// ===== sim/tb_time_reversal_overlap_ratio.sv =====
module tb_time_reversal_overlap_ratio;

  localparam int unsigned NumItems   = 1700;
  localparam int unsigned IdlePct    = 9;
  localparam int unsigned DrainWait  = 200;
  localparam int unsigned StallLimit = 3000;
  localparam int unsigned HoldCycles = 400;

  logic clk;
  logic rst_n;

  tror_in_if  in_ch ();
  tror_out_if out_ch ();

  time_reversal_overlap_ratio uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  typedef struct {
    tror_pkg::in_item_t  item;
    bit                  typed;
    tror_pkg::out_item_t want;
  } stim_row_t;

  logic signed [63:0] ovl_re_acc;
  logic signed [63:0] ovl_im_acc;
  logic [63:0]        norm_acc;

  tror_pkg::out_item_t ratio_q[$];
  int unsigned fails;
  int unsigned cycle_cnt;
  int unsigned quiet_cnt;
  bit          src_idle_en;
  bit          snk_idle_en;
  bit          hold_req;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic logic signed [63:0] qmul(logic signed [31:0] a, logic signed [31:0] b);
    logic signed [63:0] p;
    p = a * b;
    return (p + 64'sd536870912) >>> 30;
  endfunction

  function automatic logic [63:0] mag_of(logic [63:0] x);
    return x[63] ? (64'd0 - x) : x;
  endfunction

  function automatic logic [63:0] root_of(logic [127:0] s);
    logic [63:0] r;
    logic [63:0] c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if ({64'd0, c} * {64'd0, c} <= s) r = c;
    end
    return r;
  endfunction

  task automatic overlap_accum(input tror_pkg::in_item_t it, output bit has,
                               output tror_pkg::out_item_t r);
    logic [63:0]  ur;
    logic [63:0]  ui;
    logic [127:0] sq;
    logic [63:0]  mag;
    logic [127:0] quo;
    ovl_re_acc += qmul(it.a_even_im, it.b_odd_im) - qmul(it.a_even_re, it.b_odd_re)
                + qmul(it.a_odd_re, it.b_even_re) - qmul(it.a_odd_im, it.b_even_im);
    ovl_im_acc += qmul(it.a_even_re, it.b_odd_im) + qmul(it.a_even_im, it.b_odd_re)
                - qmul(it.a_odd_re, it.b_even_im) - qmul(it.a_odd_im, it.b_even_re);
    norm_acc += qmul(it.a_even_re, it.a_even_re) + qmul(it.a_even_im, it.a_even_im)
              + qmul(it.a_odd_re, it.a_odd_re) + qmul(it.a_odd_im, it.a_odd_im);
    has = it.last_item;
    r = '0;
    if (!has) return;
    if (norm_acc == 0) begin
      r.norm_zero = 1'b1;
    end else begin
      ur  = mag_of(ovl_re_acc);
      ui  = mag_of(ovl_im_acc);
      sq  = {64'd0, ur} * {64'd0, ur} + {64'd0, ui} * {64'd0, ui};
      mag = root_of(sq);
      if ((mag >> 4) >= norm_acc) begin
        r.overlap_ratio   = '1;
        r.ratio_saturated = 1'b1;
      end else begin
        quo = ({64'd0, mag} << 28) / {64'd0, norm_acc};
        r.overlap_ratio = quo[31:0];
      end
    end
    ovl_re_acc = '0;
    ovl_im_acc = '0;
    norm_acc   = '0;
  endtask

  task automatic send_item(input tror_pkg::in_item_t it, input bit typed,
                           input tror_pkg::out_item_t want);
    bit                  has;
    tror_pkg::out_item_t r;
    while (src_idle_en && $urandom_range(99) < IdlePct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk); while (!in_ch.ready);
    overlap_accum(it, has, r);
    if (has) ratio_q.push_back(typed ? want : r);
  endtask

  function automatic logic [31:0] rnd_val();
    case ($urandom_range(5))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'($signed($urandom_range(65535)) - 32768);
      3:       return $urandom() >> $urandom_range(31);
      default: return $urandom();
    endcase
  endfunction

  function automatic tror_pkg::in_item_t rnd_item(bit last, bit a_zero);
    tror_pkg::in_item_t it;
    it.a_even_re = a_zero ? '0 : rnd_val();
    it.a_even_im = a_zero ? '0 : rnd_val();
    it.a_odd_re  = a_zero ? '0 : rnd_val();
    it.a_odd_im  = a_zero ? '0 : rnd_val();
    it.b_even_re = rnd_val();
    it.b_even_im = rnd_val();
    it.b_odd_re  = rnd_val();
    it.b_odd_im  = rnd_val();
    it.last_item = last;
    return it;
  endfunction

  function automatic stim_row_t mk_row(logic [31:0] aer, logic [31:0] aei, logic [31:0] aor,
                                      logic [31:0] aoi, logic [31:0] ber, logic [31:0] bei,
                                      logic [31:0] bor, logic [31:0] boi, bit last,
                                      bit typed, logic [31:0] ratio, bit sat, bit nz);
    stim_row_t s;
    s.item  = '{aer, aei, aor, aoi, ber, bei, bor, boi, last};
    s.typed = typed;
    s.want  = '{ratio, sat, nz};
    return s;
  endfunction

  // drive
  initial begin
    stim_row_t          rows[$];
    int unsigned        sent;
    int unsigned        len;
    bit                 az;
    bit                 paused;
    tror_pkg::in_item_t it;

    rst_n       = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    ovl_re_acc  = '0;
    ovl_im_acc  = '0;
    norm_acc    = '0;
    fails       = 0;
    paused      = 1'b0;
    src_idle_en = 1'b1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    rows.push_back(mk_row(0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 32'h0, 0, 1));
    rows.push_back(mk_row(32'h4000_0000, 0, 0, 0, 0, 0, 32'hC000_0000, 0, 1,
                          1, 32'h1000_0000, 0, 0));
    rows.push_back(mk_row(1, 0, 0, 0, 0, 0, 32'h8000_0000, 0, 1, 1, 32'h0, 0, 1));
    rows.push_back(mk_row(32'h8000, 0, 0, 0, 0, 0, 32'h8000_0000, 0, 1,
                          1, 32'hFFFF_FFFF, 1, 0));
    rows.push_back(mk_row('1, '1, '1, '1, '1, '1, '1, '1, 1, 0, 0, 0, 0));
    rows.push_back(mk_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                          32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                          1, 0, 0, 0, 0));
    rows.push_back(mk_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                          32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                          1, 0, 0, 0, 0));
    rows.push_back(mk_row(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                          32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                          0, 0, 0, 0, 0));
    rows.push_back(mk_row(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                          32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                          0, 0, 0, 0, 0));
    rows.push_back(mk_row(0, 0, 32'h4000_0000, 0, 32'h4000_0000, 0, 0, 0, 1, 0, 0, 0, 0));
    rows.push_back(mk_row(0, 32'h2000_0000, 0, 32'hE000_0000, 0, 32'h4000_0000,
                          0, 32'h1000_0000, 1, 0, 0, 0, 0));
    rows.push_back(mk_row(32'h1234_5678, 32'h8765_4321, 32'h0F0F_0F0F, 32'hF0F0_F0F0,
                          32'h5555_5555, 32'hAAAA_AAAA, 32'h3333_3333, 32'hCCCC_CCCC,
                          0, 0, 0, 0, 0));
    rows.push_back(mk_row(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_8000, 32'hFFFF_8000,
                          32'h2000_0000, 32'hE000_0000, 32'h0000_0001, 32'hFFFF_FFFF,
                          1, 0, 0, 0, 0));
    foreach (rows[i]) send_item(rows[i].item, rows[i].typed, rows[i].want);

    sent = 0;
    while (sent < NumItems) begin
      len = $urandom_range(9) < 7 ? $urandom_range(1, 6) : $urandom_range(7, 40);
      az  = $urandom_range(19) == 0;
      src_idle_en = !(sent > 500 && sent < 800);
      if (!paused && sent >= 1000) begin
        paused = 1'b1;
        in_ch.valid <= 1'b0;
        wait (ratio_q.size() == 0);
        repeat (DrainWait) @(posedge clk);
      end
      for (int k = 0; k < len; k++) begin
        it = rnd_item(k == len - 1, az);
        if ($urandom_range(49) == 0) it.last_item = ~it.last_item;
        send_item(it, 1'b0, '0);
        sent++;
      end
    end
    in_ch.valid <= 1'b0;

    wait (ratio_q.size() == 0);
    repeat (DrainWait) @(posedge clk);
    if (fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    hold_req = 1'b0;
    wait (rst_n);
    repeat (3000) @(posedge clk);
    hold_req = 1'b1;
    repeat (HoldCycles) @(posedge clk);
    hold_req = 1'b0;
  end

  initial out_ch.ready = 1'b0;
  always @(posedge clk) begin
    cycle_cnt   <= rst_n ? cycle_cnt + 1 : 0;
    snk_idle_en = !(cycle_cnt > 20000 && cycle_cnt < 30000);
    if (hold_req) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !(snk_idle_en && $urandom_range(99) < IdlePct);
    end
  end

  // check
  always @(posedge clk) begin
    tror_pkg::out_item_t w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (ratio_q.size() == 0) begin
        $display("%0t: unexpected transfer, expected none, actual %h", $time, out_ch.data);
        fails++;
      end else begin
        w = ratio_q.pop_front();
        if (out_ch.data.overlap_ratio !== w.overlap_ratio) begin
          $display("%0t: overlap_ratio expected %h actual %h", $time,
                   w.overlap_ratio, out_ch.data.overlap_ratio);
          fails++;
        end
        if (out_ch.data.ratio_saturated !== w.ratio_saturated) begin
          $display("%0t: ratio_saturated expected %b actual %b", $time,
                   w.ratio_saturated, out_ch.data.ratio_saturated);
          fails++;
        end
        if (out_ch.data.norm_zero !== w.norm_zero) begin
          $display("%0t: norm_zero expected %b actual %b", $time,
                   w.norm_zero, out_ch.data.norm_zero);
          fails++;
        end
      end
    end
  end

  initial quiet_cnt = 0;
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cnt <= 0;
    end else begin
      quiet_cnt <= quiet_cnt + 1;
    end
    if (quiet_cnt >= StallLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

endmodule

// ===== files.f =====
sv/tror_pkg.sv
sv/tror_in_if.sv
sv/tror_out_if.sv
sv/tror_lane.sv
sv/tror_merge.sv
sv/tror_finish.sv
sv/time_reversal_overlap_ratio.sv
sim/tb_time_reversal_overlap_ratio.sv
